/* rtl/page_table_range_check_unit_defines.svh */
// Assertion macros shared by the page table range check RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef PAGE_TABLE_RANGE_CHECK_UNIT_DEFINES_SVH
`define PAGE_TABLE_RANGE_CHECK_UNIT_DEFINES_SVH

// Clocked assertion, masked while reset is asserted (active-low reset)
`define PTRC_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset
`define PTRC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/ptrc_pkg.sv */
// Package for the page table range check unit: field widths, sequencer types
// and the microprogram table. No dependencies.
package ptrc_pkg;

    // Field widths
    localparam int OP_W       = 1;
    localparam int WADDR_W    = 16;
    localparam int WORD_W     = 64;
    localparam int VA_W       = 48;
    localparam int COUNT_W    = 32;
    localparam int ROOT_W     = 7;

    // Table geometry
    localparam int PAGE_SHIFT = 12;
    localparam int IDX_W      = 9;
    localparam int LEVELS     = 4;
    localparam int TPAGE_W    = 36;                     // entry bits 47:12
    localparam int RDADDR_W   = TPAGE_W + IDX_W;        // table word address
    localparam int VP_W       = 38;                     // page counter incl. overflow
    localparam int SUM_W      = 50;                     // end address sum

    localparam int MEM_WORDS_DEF = 65536;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
    localparam logic [OP_W-1:0] OP_CHECK = 1'b1;

    // Sequencer steps
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_TEST,
        S_ADDR,
        S_EVAL,
        S_OK,
        S_FAIL
    } t_step;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_CLR_LAST,
        C_ACC_CHECK,
        C_RANGE_END,
        C_VA_HIGH,
        C_ADDR_OUT,
        C_ENTRY_BAD,
        C_LEVEL_LAST,
        C_OUT_BUSY
    } t_cond;

    // One control word
    typedef struct packed {
        logic  in_ready;
        logic  clear;
        logic  load_range;
        logic  start_page;
        logic  issue_rd;
        logic  eval;
        logic  result_ld;
        logic  res_val;
        t_cond cond_a;
        t_step jmp_a;
        t_cond cond_b;
        t_step jmp_b;
        t_step nxt;
    } t_uword;

    // Microprogram ROM: cond_a has priority over cond_b, else nxt
    function automatic t_uword ucode(t_step s);
        t_uword w;
        w = '{in_ready: 1'b0, clear: 1'b0, load_range: 1'b0, start_page: 1'b0,
              issue_rd: 1'b0, eval: 1'b0, result_ld: 1'b0, res_val: 1'b0,
              cond_a: C_NEVER, jmp_a: S_IDLE, cond_b: C_NEVER, jmp_b: S_IDLE,
              nxt: S_IDLE};
        unique case (s)
            S_CLEAR: begin
                w.clear  = 1'b1;
                w.cond_a = C_CLR_LAST;
                w.jmp_a  = S_IDLE;
                w.nxt    = S_CLEAR;
            end
            S_IDLE: begin
                w.in_ready = 1'b1;
                w.cond_a   = C_ACC_CHECK;
                w.jmp_a    = S_SETUP;
                w.nxt      = S_IDLE;
            end
            S_SETUP: begin
                w.load_range = 1'b1;
                w.nxt        = S_TEST;
            end
            S_TEST: begin
                w.start_page = 1'b1;
                w.cond_a     = C_RANGE_END;
                w.jmp_a      = S_OK;
                w.cond_b     = C_VA_HIGH;
                w.jmp_b      = S_FAIL;
                w.nxt        = S_ADDR;
            end
            S_ADDR: begin
                w.issue_rd = 1'b1;
                w.cond_a   = C_ADDR_OUT;
                w.jmp_a    = S_FAIL;
                w.nxt      = S_EVAL;
            end
            S_EVAL: begin
                w.eval   = 1'b1;
                w.cond_a = C_ENTRY_BAD;
                w.jmp_a  = S_FAIL;
                w.cond_b = C_LEVEL_LAST;
                w.jmp_b  = S_TEST;
                w.nxt    = S_ADDR;
            end
            S_OK: begin
                w.result_ld = 1'b1;
                w.res_val   = 1'b1;
                w.cond_a    = C_OUT_BUSY;
                w.jmp_a     = S_OK;
                w.nxt       = S_IDLE;
            end
            S_FAIL: begin
                w.result_ld = 1'b1;
                w.res_val   = 1'b0;
                w.cond_a    = C_OUT_BUSY;
                w.jmp_a     = S_FAIL;
                w.nxt       = S_IDLE;
            end
            default: begin
                w.nxt = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* rtl/ptrc_if.sv */
// Valid/ready channel interfaces of the page table range check unit:
// request channel and result channel. Depends on ptrc_pkg.
interface ptrc_req_if
    import ptrc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [WADDR_W-1:0] word_addr;
    logic [WORD_W-1:0]  word_value;
    logic [VA_W-1:0]    virt_addr;
    logic [COUNT_W-1:0] byte_count;
    logic [WORD_W-1:0]  required_flags;

    modport source (output valid, op, word_addr, word_value, virt_addr, byte_count,
                    required_flags, input ready);
    modport sink   (input valid, op, word_addr, word_value, virt_addr, byte_count,
                    required_flags, output ready);
endinterface

interface ptrc_rsp_if;
    logic valid;
    logic ready;
    logic range_ok;

    modport source (output valid, range_ok, input ready);
    modport sink   (input valid, range_ok, output ready);
endinterface

/* rtl/page_table_range_check_unit.sv */
// Page table range check unit: table memory, microcoded sequencer and datapath.
// Depends on ptrc_pkg, ptrc_if.sv and page_table_range_check_unit_defines.svh.

// After reset the unit sweeps the table memory to zero, one word per cycle, over
// all MEM_WORDS words; no request transfer is taken during that pass, while
// root_table_page writes are taken at any time. A write request yields no result.
// A check request walks each 4 KiB page of the range and stops at the first page
// that fails: each page costs one test step plus four read/evaluate pairs on the
// single table memory read port, whose registered read must return before the
// next level's address is known. One result per check leaves through an output
// register, so a new request is accepted while the previous result still waits.
module page_table_range_check_unit
    import ptrc_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [ROOT_W-1:0] i_cfg_wr_data,
    ptrc_req_if.sink          i_req,
    ptrc_rsp_if.source        o_rsp
);

`include "page_table_range_check_unit_defines.svh"

    localparam int AW = $clog2(MEM_WORDS);

    // Sequencer state and control word
    t_step  r_step, n_step;
    t_uword uw;
    logic   cond_a_hit, cond_b_hit;

    // Datapath registers
    logic [ROOT_W-1:0]  r_root;
    logic [AW-1:0]      r_clr_addr;
    logic [VA_W-1:0]    r_virt;
    logic [COUNT_W-1:0] r_count;
    logic [WORD_W-1:0]  r_flags;
    logic [VP_W-1:0]    r_vp;
    logic [VP_W-1:0]    r_ep;
    logic [TPAGE_W-1:0] r_base;
    logic [1:0]         r_level;
    logic [WORD_W-1:0]  r_rdata;
    logic               r_out_valid;
    logic               r_range_ok;

    // Table memory
    logic [WORD_W-1:0]  mem [MEM_WORDS];

    // Derived signals
    logic               acc;
    logic               out_busy;
    logic [IDX_W-1:0]   idx;
    logic [RDADDR_W-1:0] rd_word;
    logic               addr_out;
    logic               level_last;
    logic               flags_fail;
    logic               entry_bad;
    logic [31:0]        wa_ext;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [WORD_W-1:0]  mem_wd;
    logic [SUM_W-1:0]   end_sum;

    // Control word for the current step
    always_comb begin
        uw = ucode(r_step);
    end

    assign i_req.ready = uw.in_ready;
    assign acc         = i_req.valid && uw.in_ready;
    assign out_busy    = r_out_valid && !o_rsp.ready;

    // Level index from the page number
    always_comb begin
        unique case (r_level)
            2'd0:    idx = r_vp[4*IDX_W-1:3*IDX_W];
            2'd1:    idx = r_vp[3*IDX_W-1:2*IDX_W];
            2'd2:    idx = r_vp[2*IDX_W-1:IDX_W];
            default: idx = r_vp[IDX_W-1:0];
        endcase
    end

    assign rd_word    = {r_base, idx};
    assign addr_out   = rd_word >= RDADDR_W'(MEM_WORDS);
    assign level_last = r_level == 2'(LEVELS - 1);
    assign flags_fail = (r_rdata & r_flags) != r_flags;
    assign entry_bad  = !r_rdata[0] || (level_last && flags_fail);

    // Range end page: (virt + count + page-1) >> 12
    assign end_sum = SUM_W'(r_virt) + SUM_W'(r_count) + SUM_W'((1 << PAGE_SHIFT) - 1);

    // Condition evaluation
    always_comb begin
        unique case (uw.cond_a)
            C_NEVER:      cond_a_hit = 1'b0;
            C_CLR_LAST:   cond_a_hit = r_clr_addr == AW'(MEM_WORDS - 1);
            C_ACC_CHECK:  cond_a_hit = acc && (i_req.op == OP_CHECK);
            C_RANGE_END:  cond_a_hit = r_vp >= r_ep;
            C_VA_HIGH:    cond_a_hit = r_vp[VP_W-1:TPAGE_W] != '0;
            C_ADDR_OUT:   cond_a_hit = addr_out;
            C_ENTRY_BAD:  cond_a_hit = entry_bad;
            C_LEVEL_LAST: cond_a_hit = level_last;
            C_OUT_BUSY:   cond_a_hit = out_busy;
            default:      cond_a_hit = 1'b0;
        endcase
        unique case (uw.cond_b)
            C_NEVER:      cond_b_hit = 1'b0;
            C_CLR_LAST:   cond_b_hit = r_clr_addr == AW'(MEM_WORDS - 1);
            C_ACC_CHECK:  cond_b_hit = acc && (i_req.op == OP_CHECK);
            C_RANGE_END:  cond_b_hit = r_vp >= r_ep;
            C_VA_HIGH:    cond_b_hit = r_vp[VP_W-1:TPAGE_W] != '0;
            C_ADDR_OUT:   cond_b_hit = addr_out;
            C_ENTRY_BAD:  cond_b_hit = entry_bad;
            C_LEVEL_LAST: cond_b_hit = level_last;
            C_OUT_BUSY:   cond_b_hit = out_busy;
            default:      cond_b_hit = 1'b0;
        endcase
    end

    // Next step
    always_comb begin
        priority if (cond_a_hit) begin
            n_step = uw.jmp_a;
        end else if (cond_b_hit) begin
            n_step = uw.jmp_b;
        end else begin
            n_step = uw.nxt;
        end
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_CLEAR;
        end else begin
            r_step <= n_step;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
        end else if (i_cfg_wr_en) begin
            r_root <= i_cfg_wr_data;
        end
    end

    // Clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (uw.clear) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Request capture, range setup and walk registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else begin
            if (acc && i_req.op == OP_CHECK) begin
                r_virt  <= i_req.virt_addr;
                r_count <= i_req.byte_count;
                r_flags <= i_req.required_flags;
            end
            if (uw.load_range) begin
                r_vp <= VP_W'(r_virt[VA_W-1:PAGE_SHIFT]);
                r_ep <= end_sum[SUM_W-1:PAGE_SHIFT];
            end
            if (uw.start_page) begin
                r_level <= '0;
                r_base  <= TPAGE_W'(r_root);
            end
            if (uw.eval) begin
                if (level_last) begin
                    r_vp <= r_vp + VP_W'(1);
                end else begin
                    r_level <= r_level + 2'd1;
                    r_base  <= r_rdata[PAGE_SHIFT+TPAGE_W-1:PAGE_SHIFT];
                end
            end
        end
    end

    // Table memory write source: clearing pass or write request
    assign wa_ext = 32'(i_req.word_addr);
    always_comb begin
        priority if (uw.clear) begin
            mem_we = 1'b1;
            mem_wa = r_clr_addr;
            mem_wd = '0;
        end else begin
            mem_we = acc && (i_req.op == OP_WRITE) && (wa_ext < 32'(MEM_WORDS));
            mem_wa = wa_ext[AW-1:0];
            mem_wd = i_req.word_value;
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (uw.issue_rd) begin
            r_rdata <= mem[rd_word[AW-1:0]];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uw.result_ld && !out_busy) begin
            r_out_valid <= 1'b1;
            r_range_ok  <= uw.res_val;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.range_ok = r_range_ok;

    // Assertions
    `PTRC_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> r_step == S_CLEAR,
        "sequencer does not start with the clearing pass")
    `PTRC_ASSERT_RST(a_result_held, i_clk, i_rst_n,
        out_busy |=> r_out_valid && $stable(r_range_ok), "pending result overwritten")
    `PTRC_ASSERT_RST(a_read_in_range, i_clk, i_rst_n,
        (r_step == S_ADDR && !addr_out) |=> r_step == S_EVAL,
        "in-range table read did not reach evaluation")
    `PTRC_ASSERT_RST(a_level_step, i_clk, i_rst_n,
        (r_step == S_EVAL && !entry_bad && !level_last) |=>
            (r_level == $past(r_level) + 2'd1) && r_step == S_ADDR,
        "walk did not descend one level")
    `PTRC_ASSERT_RST(a_page_step, i_clk, i_rst_n,
        (r_step == S_EVAL && !entry_bad && level_last) |=>
            (r_vp == $past(r_vp) + VP_W'(1)) && r_step == S_TEST,
        "walk did not advance to the next page")

endmodule
